[src/assert_macros.svh]
// ------------------------------------------------------------------------
// assert_macros.svh
// Assertion helpers for the decoder. They compile to nothing under
// SYNTHESIS.
// ------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_SAME(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

[src/utfdec_pkg.sv]
// ------------------------------------------------------------------------
// utfdec_pkg
// Types and constants shared by the UTF-8 to UTF-16 decoder.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

package utfdec_pkg;

    localparam int unsigned MAX_UNITS = 4;

    localparam logic [15:0] REPLACEMENT = 16'hFFFD;
    localparam logic [20:0] MAX_CODE    = 21'h10FFFF;
    localparam logic [15:0] HIGH_BASE   = 16'hD7C0;
    localparam logic [15:0] LOW_BASE    = 16'hDC00;
    localparam logic [20:0] BOM_CODE    = 21'h00FEFF;
    localparam logic [7:0]  CONT_MASK   = 8'hC0;
    localparam logic [7:0]  CONT_TAG    = 8'h80;
    localparam logic [7:0]  LEAD_MIN    = 8'hC2;
    localparam logic [7:0]  LEAD_LIMIT  = 8'hF5;
    localparam logic [7:0]  LEAD3_MIN   = 8'hE0;
    localparam logic [7:0]  LEAD4_MIN   = 8'hF0;

    // Up to four code units produced by one input word.
    typedef struct packed {
        logic [2:0]       count;
        logic [3:0]       err;
        logic [3:0][15:0] unit;
        logic             msg_last;
    } batch_t;

endpackage

[src/utfdec_if.sv]
// ------------------------------------------------------------------------
// utfdec_byte_if / utfdec_unit_if
// Valid/ready channels for UTF-8 bytes in and UTF-16 code units out.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

interface utfdec_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       last_byte;

    modport source (output valid, data_byte, last_byte, input ready);
    modport sink   (input valid, data_byte, last_byte, output ready);
endinterface

interface utfdec_unit_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_unit;
    logic        is_error;
    logic        run_end;
    logic        message_end;

    modport source (output valid, code_unit, is_error, run_end, message_end, input ready);
    modport sink   (input valid, code_unit, is_error, run_end, message_end, output ready);
endinterface

[src/utfdec_core.sv]
// ------------------------------------------------------------------------
// utfdec_core
// Sequence state and single-pass decode of one byte into a batch of up
// to four UTF-16 code units.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module utfdec_core (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                take,
    input  logic [7:0]          data_byte,
    input  logic                last_byte,
    output utfdec_pkg::batch_t  batch
);

    logic [2:0]  needed_len_reg, needed_len_next;
    logic [1:0]  taken_cont_reg, taken_cont_next;
    logic [20:0] code_accum_reg, code_accum_next;
    logic        msg_start_reg,  msg_start_next;

    // Decode of the byte as a fresh lead.
    logic        fr_ascii;
    logic        fr_bad;
    logic [2:0]  fr_len;
    logic [20:0] fr_bits;
    logic        is_cont;

    // Continuation path.
    logic [20:0] acc_cat;
    logic [2:0]  tk_count;
    logic        complete;
    logic [20:0] lowest;
    logic        cp_bad;
    logic        do_fresh;

    // Result assembly.
    logic [2:0]  n_err;
    logic [1:0]  n_tail;
    logic [15:0] tail0;
    logic [15:0] tail1;
    logic        tail0_err;
    logic [1:0]  tail_idx;

    // State registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            needed_len_reg <= 3'd0;
            taken_cont_reg <= 2'd0;
            code_accum_reg <= 21'd0;
            msg_start_reg  <= 1'b1;
        end
        else if (take)
        begin
            needed_len_reg <= needed_len_next;
            taken_cont_reg <= taken_cont_next;
            code_accum_reg <= code_accum_next;
            msg_start_reg  <= msg_start_next;
        end
    end

    // Classify the byte as a lead and gather the continuation bits.
    always_comb
    begin
        fr_ascii = (data_byte < utfdec_pkg::CONT_TAG);
        fr_bad   = !fr_ascii && ((data_byte < utfdec_pkg::LEAD_MIN) ||
                                 (data_byte >= utfdec_pkg::LEAD_LIMIT));
        if (data_byte < utfdec_pkg::LEAD3_MIN)
        begin
            fr_len  = 3'd2;
            fr_bits = {16'd0, data_byte[4:0]};
        end
        else if (data_byte < utfdec_pkg::LEAD4_MIN)
        begin
            fr_len  = 3'd3;
            fr_bits = {17'd0, data_byte[3:0]};
        end
        else
        begin
            fr_len  = 3'd4;
            fr_bits = {18'd0, data_byte[2:0]};
        end

        is_cont  = ((data_byte & utfdec_pkg::CONT_MASK) == utfdec_pkg::CONT_TAG);
        acc_cat  = {code_accum_reg[14:0], data_byte[5:0]};
        tk_count = {1'b0, taken_cont_reg} + 3'd1;
        complete = ({1'b0, tk_count} + 4'd1) >= {1'b0, needed_len_reg};

        case (needed_len_reg)
            3'd2:    lowest = 21'h000080;
            3'd3:    lowest = 21'h000800;
            default: lowest = 21'h010000;
        endcase
        cp_bad = (acc_cat < lowest) ||
                 ((acc_cat >= 21'h00D800) && (acc_cat <= 21'h00DFFF)) ||
                 (acc_cat > utfdec_pkg::MAX_CODE);
    end

    // Next state and the units this byte produces.
    always_comb
    begin
        needed_len_next = needed_len_reg;
        taken_cont_next = taken_cont_reg;
        code_accum_next = code_accum_reg;
        msg_start_next  = msg_start_reg;
        n_err     = 3'd0;
        n_tail    = 2'd0;
        tail0     = 16'd0;
        tail1     = 16'd0;
        tail0_err = 1'b0;
        do_fresh  = 1'b0;

        if (needed_len_reg != 3'd0)
        begin
            if (is_cont)
            begin
                code_accum_next = acc_cat;
                taken_cont_next = tk_count[1:0];
                if (complete)
                begin
                    // Sequence closes: check the code point and emit it.
                    if (cp_bad)
                    begin
                        n_err = needed_len_reg;
                    end
                    else if (msg_start_reg && (needed_len_reg == 3'd3) &&
                             (acc_cat == utfdec_pkg::BOM_CODE))
                    begin
                        n_tail = 2'd0;
                    end
                    else if (acc_cat >= 21'h010000)
                    begin
                        n_tail = 2'd2;
                        tail0  = acc_cat[20:10] + utfdec_pkg::HIGH_BASE;
                        tail1  = {6'd0, acc_cat[9:0]} + utfdec_pkg::LOW_BASE;
                    end
                    else
                    begin
                        n_tail = 2'd1;
                        tail0  = acc_cat[15:0];
                    end
                    needed_len_next = 3'd0;
                    taken_cont_next = 2'd0;
                    code_accum_next = 21'd0;
                    msg_start_next  = 1'b0;
                end
                else if (last_byte)
                begin
                    // Message ends inside the sequence.
                    n_err = tk_count + 3'd1;
                    msg_start_next = 1'b0;
                end
            end
            else
            begin
                // A breaking byte flushes the pending bytes, then starts over.
                n_err           = tk_count;
                needed_len_next = 3'd0;
                taken_cont_next = 2'd0;
                code_accum_next = 21'd0;
                msg_start_next  = 1'b0;
                do_fresh        = 1'b1;
            end
        end
        else
        begin
            do_fresh = 1'b1;
        end

        if (do_fresh)
        begin
            if (fr_ascii)
            begin
                n_tail = 2'd1;
                tail0  = {8'd0, data_byte};
                msg_start_next = 1'b0;
            end
            else if (fr_bad)
            begin
                n_tail    = 2'd1;
                tail0     = utfdec_pkg::REPLACEMENT;
                tail0_err = 1'b1;
                msg_start_next = 1'b0;
            end
            else
            begin
                needed_len_next = fr_len;
                code_accum_next = fr_bits;
                taken_cont_next = 2'd0;
                if (last_byte)
                begin
                    n_tail    = 2'd1;
                    tail0     = utfdec_pkg::REPLACEMENT;
                    tail0_err = 1'b1;
                end
            end
        end

        // End of message closes everything and rearms the mark check.
        if (last_byte)
        begin
            needed_len_next = 3'd0;
            taken_cont_next = 2'd0;
            code_accum_next = 21'd0;
            msg_start_next  = 1'b1;
        end
    end

    // Replacements first, then the decoded units.
    always_comb
    begin
        tail_idx = 2'd0;
        batch.count    = n_err + {1'b0, n_tail};
        batch.msg_last = last_byte;
        for (int i = 0; i < 4; i++)
        begin
            tail_idx = 2'(i) - n_err[1:0];
            if (3'(i) < n_err)
            begin
                batch.unit[i] = utfdec_pkg::REPLACEMENT;
                batch.err[i]  = 1'b1;
            end
            else if (tail_idx == 2'd0)
            begin
                batch.unit[i] = tail0;
                batch.err[i]  = tail0_err;
            end
            else
            begin
                batch.unit[i] = tail1;
                batch.err[i]  = 1'b0;
            end
        end
    end

endmodule

[src/utf8_to_utf16_decoder_top.sv]
// The first code unit of a byte is offered in the cycle after the byte is taken.
// One byte per cycle while the output is ready and each byte yields at most one unit; a byte
// that yields several units (up to four) holds the output register until its last unit leaves.
// The output batch register is the only limit on rate; a new byte is taken in the
// cycle its predecessor's last unit leaves. Reset is asynchronous and clears state.
// ------------------------------------------------------------------------
// utf8_to_utf16_decoder_top
// Streaming UTF-8 to UTF-16 decoder with replacement on invalid input.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module utf8_to_utf16_decoder_top (
    input  logic          clk,
    input  logic          rst_n,
    utfdec_byte_if.sink   utf8,
    utfdec_unit_if.source utf16
);

    utfdec_pkg::batch_t batch_next;
    utfdec_pkg::batch_t batch_reg;
    logic [1:0]         idx_reg;
    logic               busy;
    logic               last_out;
    logic               take;
    logic               out_fire;

    assign busy     = (batch_reg.count != 3'd0);
    assign last_out = ({1'b0, idx_reg} + 3'd1) == batch_reg.count;
    assign out_fire = utf16.valid && utf16.ready;
    assign utf8.ready = !busy || (utf16.ready && last_out);
    assign take     = utf8.valid && utf8.ready;

    utfdec_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .data_byte (utf8.data_byte),
        .last_byte (utf8.last_byte),
        .batch     (batch_next)
    );

    // Batch register: loaded on an accepted byte, drained one unit per word.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            batch_reg <= '0;
            idx_reg   <= 2'd0;
        end
        else if (take)
        begin
            batch_reg <= batch_next;
            idx_reg   <= 2'd0;
        end
        else if (out_fire)
        begin
            if (last_out)
            begin
                batch_reg.count <= 3'd0;
                idx_reg         <= 2'd0;
            end
            else
            begin
                idx_reg <= idx_reg + 2'd1;
            end
        end
    end

    // Output word selection.
    assign utf16.valid       = busy;
    assign utf16.code_unit   = batch_reg.unit[idx_reg];
    assign utf16.is_error    = batch_reg.err[idx_reg];
    assign utf16.run_end     = last_out;
    assign utf16.message_end = last_out && batch_reg.msg_last;

    // The drain index never runs past the batch.
    `ASSERT_SAME(a_idx_in_batch, clk, rst_n, busy, ({1'b0, idx_reg} < batch_reg.count))
    // A byte is taken while busy only as the final unit leaves.
    `ASSERT_SAME(a_take_on_drain, clk, rst_n, take && busy, out_fire && utf16.run_end)
    // A partly drained batch keeps the output valid.
    `ASSERT_NEXT(a_batch_holds, clk, rst_n, out_fire && !last_out, utf16.valid)

endmodule

[test/tb_utf8_to_utf16_decoder_top.sv]
// ------------------------------------------------------------------------
// tb_utf8_to_utf16_decoder_top
// Drives UTF-8 words into the decoder and checks every UTF-16 code unit
// against a predictor that follows the decoding rules bit for bit. A short
// directed stream covers the edge cases, then random well-formed and broken
// sequences run under three idle patterns and forced back-pressure.
// ------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_utf8_to_utf16_decoder_top;

    localparam int unsigned STALL_LIMIT   = 1000;
    localparam int unsigned PHASE_WORDS   = 64;
    localparam int unsigned LONG_HOLD     = 60;
    localparam int unsigned TAIL_CYCLES   = 8;
    localparam int unsigned REPORT_LIMIT  = 10;

    localparam logic [20:0] MIN_TWO       = 21'h000080;
    localparam logic [20:0] MIN_THREE     = 21'h000800;
    localparam logic [20:0] MIN_FOUR      = 21'h010000;
    localparam logic [20:0] SURR_FIRST    = 21'h00D800;
    localparam logic [20:0] SURR_LAST     = 21'h00DFFF;

    // Directed words as {last_byte, data_byte}.
    localparam int unsigned DIRECTED_LEN = 29;
    localparam logic [8:0] DIRECTED [DIRECTED_LEN] = '{
        9'h0EF, 9'h0BB, 9'h0BF,                 // byte order mark, dropped
        9'h000, 9'h07F,                         // ASCII extremes
        9'h0C2, 9'h080,                         // smallest two-word form
        9'h0F4, 9'h08F, 9'h0BF, 9'h0BF,         // U+10FFFF as a surrogate pair
        9'h080, 9'h0C1, 9'h0F5,                 // rejected lead words
        9'h0E0, 9'h080, 9'h080,                 // overlong form
        9'h0ED, 9'h0A0, 9'h080,                 // surrogate code point
        9'h0F0, 9'h090, 9'h080, 9'h041,         // breaking word after three taken
        9'h0F0, 9'h19F,                         // truncation by end of message
        9'h0EF, 9'h0BB, 9'h1BF                  // mark as the whole message
    };

    typedef struct packed {
        logic [15:0] code_unit;
        logic        is_error;
        logic        run_end;
        logic        message_end;
    } unit_rec_t;

    // Predicts the code units of each accepted word and checks the output.
    class utf16_unit_scoreboard;
        unit_rec_t   expected_units[$];
        logic [2:0]  seq_len;
        logic [1:0]  cont_seen;
        logic [20:0] code_bits;
        logic        msg_open;
        logic [15:0] step_units[utfdec_pkg::MAX_UNITS];
        logic        step_errs[utfdec_pkg::MAX_UNITS];
        int unsigned step_n;
        int unsigned failures;
        int unsigned reported;

        function new();
            expected_units.delete();
            seq_len   = '0;
            cont_seen = '0;
            code_bits = '0;
            msg_open  = 1'b1;
            failures  = 0;
            reported  = 0;
        endfunction

        function void clear_seq();
            seq_len   = '0;
            cont_seen = '0;
            code_bits = '0;
        endfunction

        function void push_unit(logic [15:0] cu, logic err);
            if (step_n < utfdec_pkg::MAX_UNITS)
            begin
                step_units[step_n] = cu;
                step_errs[step_n]  = err;
                step_n++;
            end
        endfunction

        function void push_errors(int unsigned count);
            for (int unsigned i = 0; i < count; i++)
                push_unit(utfdec_pkg::REPLACEMENT, 1'b1);
        endfunction

        // A complete sequence: reject bad code points, drop the mark, split
        // supplementary code points into a surrogate pair.
        function void close_seq();
            logic [20:0] floor_cp;
            logic [20:0] high_half;
            logic        bad;
            floor_cp = (seq_len == 3'd2) ? MIN_TWO :
                       (seq_len == 3'd3) ? MIN_THREE : MIN_FOUR;
            bad = (code_bits < floor_cp) ||
                  (code_bits >= SURR_FIRST && code_bits <= SURR_LAST) ||
                  (code_bits > utfdec_pkg::MAX_CODE);
            if (bad)
                push_errors(seq_len);
            else if (msg_open && seq_len == 3'd3 && code_bits == utfdec_pkg::BOM_CODE)
                ;
            else if (code_bits >= MIN_FOUR)
            begin
                high_half = (code_bits >> 10) + {5'd0, utfdec_pkg::HIGH_BASE};
                push_unit(high_half[15:0], 1'b0);
                push_unit({6'd0, code_bits[9:0]} + utfdec_pkg::LOW_BASE, 1'b0);
            end
            else
                push_unit(code_bits[15:0], 1'b0);
            clear_seq();
            msg_open = 1'b0;
        endfunction

        // A word seen with no sequence pending.
        function void decode_fresh(logic [7:0] b, logic last);
            if (b < utfdec_pkg::CONT_TAG)
            begin
                push_unit({8'd0, b}, 1'b0);
                msg_open = 1'b0;
                return;
            end
            if (b < utfdec_pkg::LEAD_MIN || b >= utfdec_pkg::LEAD_LIMIT)
            begin
                push_errors(1);
                msg_open = 1'b0;
                return;
            end
            if (b < utfdec_pkg::LEAD3_MIN)
            begin
                seq_len   = 3'd2;
                code_bits = {16'd0, b[4:0]};
            end
            else if (b < utfdec_pkg::LEAD4_MIN)
            begin
                seq_len   = 3'd3;
                code_bits = {17'd0, b[3:0]};
            end
            else
            begin
                seq_len   = 3'd4;
                code_bits = {18'd0, b[2:0]};
            end
            cont_seen = '0;
            if (last)
            begin
                push_errors(1);
                clear_seq();
                msg_open = 1'b0;
            end
        endfunction

        // Note one accepted word and queue the units it should produce.
        function void predict_units(logic [7:0] b, logic last);
            unit_rec_t rec;
            step_n = 0;
            if (seq_len != 3'd0)
            begin
                if ((b & utfdec_pkg::CONT_MASK) == utfdec_pkg::CONT_TAG)
                begin
                    code_bits = {code_bits[14:0], b[5:0]};
                    cont_seen = cont_seen + 2'd1;
                    if (cont_seen + 1 >= seq_len)
                        close_seq();
                    else if (last)
                    begin
                        push_errors(cont_seen + 1);
                        clear_seq();
                        msg_open = 1'b0;
                    end
                end
                else
                begin
                    push_errors(cont_seen + 1);
                    clear_seq();
                    msg_open = 1'b0;
                    decode_fresh(b, last);
                end
            end
            else
                decode_fresh(b, last);
            if (last)
            begin
                clear_seq();
                msg_open = 1'b1;
            end
            for (int unsigned i = 0; i < step_n; i++)
            begin
                rec.code_unit   = step_units[i];
                rec.is_error    = step_errs[i];
                rec.run_end     = (i == step_n - 1);
                rec.message_end = (i == step_n - 1) && last;
                expected_units.push_back(rec);
            end
        endfunction

        // Compare one accepted code unit with the oldest expected one.
        function void check_unit(logic [15:0] cu, logic err, logic re, logic me);
            unit_rec_t want;
            if (expected_units.size() == 0)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("unexpected unit %h err %b run_end %b msg_end %b",
                             cu, err, re, me);
                end
                return;
            end
            want = expected_units.pop_front();
            if (want.code_unit !== cu || want.is_error !== err ||
                want.run_end !== re || want.message_end !== me)
            begin
                failures++;
                if (reported < REPORT_LIMIT)
                begin
                    reported++;
                    $display("mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
                             want.code_unit, want.is_error, want.run_end,
                             want.message_end, cu, err, re, me);
                end
            end
        endfunction

        function int unsigned units_waiting();
            return expected_units.size();
        endfunction
    endclass

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    utfdec_byte_if utf8_ch ();
    utfdec_unit_if utf16_ch ();

    utf8_to_utf16_decoder_top dut (
        .clk   (clk),
        .rst_n (rst_n),
        .utf8  (utf8_ch),
        .utf16 (utf16_ch)
    );

    utf16_unit_scoreboard sb = new();

    int unsigned tx_idle_pct  = 35;
    int unsigned rx_idle_pct  = 65;
    int unsigned hold_request = 0;
    int unsigned quiet_cycles = 0;
    logic [7:0]  chunk_words[$];

    // Clock, 2 ns period.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Receiver: random ready, plus a long hold-off on request.
    initial
    begin
        int unsigned hold_left;
        hold_left = 0;
        utf16_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_request != 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left != 0)
            begin
                hold_left--;
                utf16_ch.ready <= 1'b0;
            end
            else
                utf16_ch.ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    // Monitor both channels and count cycles with no progress.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (utf8_ch.valid && utf8_ch.ready)
                sb.predict_units(utf8_ch.data_byte, utf8_ch.last_byte);
            if (utf16_ch.valid && utf16_ch.ready)
                sb.check_unit(utf16_ch.code_unit, utf16_ch.is_error,
                              utf16_ch.run_end, utf16_ch.message_end);
        end
        if ((utf8_ch.valid && utf8_ch.ready) || (utf16_ch.valid && utf16_ch.ready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
    end

    // Watchdog on stalled progress.
    initial
    begin
        wait (quiet_cycles >= STALL_LIMIT);
        $display("*** FAILED ***");
        $finish;
    end

    // Offer one word, idling at random first; valid stays high after it.
    task automatic send_word(input logic [7:0] d, input logic l);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            utf8_ch.valid <= 1'b0;
            @(posedge clk);
        end
        utf8_ch.valid     <= 1'b1;
        utf8_ch.data_byte <= d;
        utf8_ch.last_byte <= l;
        do
            @(posedge clk);
        while (!utf8_ch.ready);
    endtask

    // Stop offering and wait until every expected unit has arrived.
    task automatic drain_units();
        utf8_ch.valid <= 1'b0;
        do
            @(negedge clk);
        while (sb.units_waiting() != 0);
        @(posedge clk);
    endtask

    // Append the UTF-8 form of cp with the given length to the chunk.
    function automatic void encode_cp(logic [20:0] cp, int unsigned len);
        case (len)
            1: chunk_words.push_back({1'b0, cp[6:0]});
            2:
            begin
                chunk_words.push_back({3'b110, cp[10:6]});
                chunk_words.push_back({2'b10, cp[5:0]});
            end
            3:
            begin
                chunk_words.push_back({4'b1110, cp[15:12]});
                chunk_words.push_back({2'b10, cp[11:6]});
                chunk_words.push_back({2'b10, cp[5:0]});
            end
            default:
            begin
                chunk_words.push_back({5'b11110, cp[20:18]});
                chunk_words.push_back({2'b10, cp[17:12]});
                chunk_words.push_back({2'b10, cp[11:6]});
                chunk_words.push_back({2'b10, cp[5:0]});
            end
        endcase
    endfunction

    // Build one random chunk: mostly valid sequences, some invalid or noise.
    function automatic void build_chunk(logic msg_fresh);
        int unsigned kind;
        int unsigned len;
        int unsigned keep;
        chunk_words.delete();
        kind = $urandom_range(99);
        if (msg_fresh && $urandom_range(3) == 0)
            encode_cp(utfdec_pkg::BOM_CODE, 3);
        else if (kind < 20)
            encode_cp(21'($urandom_range(8'h7F)), 1);
        else if (kind < 35)
            encode_cp(21'($urandom_range(MIN_THREE - 1, MIN_TWO)), 2);
        else if (kind < 52)
            encode_cp(21'($urandom_range(16'hFFFF, MIN_THREE)), 3);
        else if (kind < 66)
            encode_cp(21'($urandom_range(utfdec_pkg::MAX_CODE, MIN_FOUR)), 4);
        else if (kind < 71)
        begin
            // Overlong: a code point encoded in more words than it needs.
            len = $urandom_range(4, 2);
            encode_cp(21'($urandom_range((len == 2) ? 8'h7F :
                                         (len == 3) ? 12'h7FF : 16'hFFFF)), len);
        end
        else if (kind < 75)
            encode_cp(21'($urandom_range(SURR_LAST, SURR_FIRST)), 3);
        else if (kind < 78)
            encode_cp(21'($urandom_range(21'h13FFFF, 21'h110000)), 4);
        else if (kind < 86)
        begin
            // Unfinished sequence, broken by whatever follows it.
            len = $urandom_range(4, 2);
            encode_cp((len == 2) ? MIN_TWO : (len == 3) ? MIN_THREE : MIN_FOUR, len);
            chunk_words[1] = {2'b10, 6'($urandom_range(63))};
            keep = $urandom_range(len - 1, 1);
            while (chunk_words.size() > keep)
                void'(chunk_words.pop_back());
        end
        else
            chunk_words.push_back(8'($urandom_range(255)));
    endfunction

    // Main stimulus.
    initial
    begin
        int unsigned sent;
        logic        mark_last;
        logic        msg_fresh;
        utf8_ch.valid     = 1'b0;
        utf8_ch.data_byte = '0;
        utf8_ch.last_byte = 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed edge cases.
        for (int unsigned i = 0; i < DIRECTED_LEN; i++)
            send_word(DIRECTED[i][7:0], DIRECTED[i][8]);
        drain_units();

        // Random phases with changing idle patterns.
        msg_fresh = 1'b1;
        for (int phase = 0; phase < 3; phase++)
        begin
            tx_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 65 : 0;
            rx_idle_pct = (phase == 0) ? 65 : (phase == 1) ? 35 : 0;
            // Stall the output while words keep coming, so the input backs up.
            if (phase == 2)
                hold_request = LONG_HOLD;
            sent = 0;
            while (sent < PHASE_WORDS)
            begin
                build_chunk(msg_fresh);
                mark_last = ($urandom_range(5) == 0);
                foreach (chunk_words[i])
                begin
                    send_word(chunk_words[i], mark_last && (i == chunk_words.size() - 1));
                    sent++;
                end
                msg_fresh = mark_last;
            end
            drain_units();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        if (sb.failures == 0 && sb.units_waiting() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
+incdir+src
src/utfdec_pkg.sv
src/utfdec_if.sv
src/utfdec_core.sv
src/utf8_to_utf16_decoder_top.sv
test/tb_utf8_to_utf16_decoder_top.sv
